[rtl/core/sync_word_serial_link_core_assert.svh]
// -----------------------------------------------------------------------------
// sync_word_serial_link_core_assert.svh
// Assertion macros shared by the link checker.
// -----------------------------------------------------------------------------
`ifndef SYNC_WORD_SERIAL_LINK_CORE_ASSERT_SVH
`define SYNC_WORD_SERIAL_LINK_CORE_ASSERT_SVH

// same-cycle implication, off while reset is low
`define SWSL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("swsl assertion failed");

// next-cycle implication, off while reset is low
`define SWSL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("swsl assertion failed");

`endif

[rtl/core/swsl_pkg.sv]
// -----------------------------------------------------------------------------
// swsl_pkg
// Types and constants for the sync-word serial link core.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

package swsl_pkg;

    localparam int MSG_DEPTH = 16;
    localparam int MSG_IDX_W = (MSG_DEPTH > 1) ? $clog2(MSG_DEPTH) : 1;
    localparam int MSG_CNT_W = $clog2(MSG_DEPTH + 1);

    localparam logic [MSG_CNT_W-1:0] MSG_DEPTH_CNT = MSG_CNT_W'(MSG_DEPTH);

    localparam logic [7:0] SYNC_RESET   = 8'hEC;
    localparam logic [7:0] FILL_LOW     = 8'h00;
    localparam logic [7:0] FILL_HIGH    = 8'hFF;
    localparam logic [7:0] NEWLINE_CHAR = 8'd10;
    localparam logic [2:0] BIT_TOP      = 3'd7;

    // request codes
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_CHAR = 1'b1;

    typedef struct packed {
        logic       req_type;
        logic       rx_bit;
        logic [7:0] char_in;
    } t_in_word;

    typedef struct packed {
        logic       tx_level;
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic       calib_event;
        logic       msg_pending;
    } t_out_word;

endpackage

[rtl/core/sync_word_serial_link_core.sv]
// -----------------------------------------------------------------------------
// sync_word_serial_link_core
// Bit-serial link: sync-word receiver, message buffer and serial transmitter.
// -----------------------------------------------------------------------------
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+------------------------
//  in      | input     | i_in_valid / o_in_ready     | i_in_word  (t_in_word)
//  out     | output    | o_out_valid / i_out_ready   | o_out_word (t_out_word)
//  cfg     | input     | i_cfg_valid / o_cfg_ready   | i_cfg_data (sync word)
//
//  One word per cycle while o_in_ready is high: all link state updates on the
//  edge that accepts a word, and its result lands in the output register, or
//  in the skid when the register is stalled, on that same edge. The output
//  side holds two results (register plus skid), so one more word is taken
//  while the output stalls; o_in_ready drops only when both are full.
//  Reset is synchronous, active low; the message store is not cleared.
//  o_cfg_ready is always high; write the sync word only while idle.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sync_word_serial_link_core
    import swsl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_word   i_in_word,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_word  o_out_word,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);

    // ---------------- state ----------------
    logic [7:0]           r_sync_word;
    logic [7:0]           r_rx_shift,     n_rx_shift;
    logic [2:0]           r_rx_bit_count, n_rx_bit_count;
    logic                 r_calibrated,   n_calibrated;
    logic [7:0]           r_msg_store [MSG_DEPTH];
    logic [MSG_CNT_W-1:0] r_msg_length,   n_msg_length;
    logic                 r_msg_ready,    n_msg_ready;
    logic [MSG_CNT_W-1:0] r_write_index,  n_write_index;
    logic [MSG_CNT_W-1:0] r_read_index,   n_read_index;
    logic [2:0]           r_tx_bit_index, n_tx_bit_index;
    logic [2:0]           r_tx_phase,     n_tx_phase;
    logic                 r_line_level,   n_line_level;

    logic       accept;
    logic       store_we;
    logic [7:0] rx_assembled;
    logic [7:0] tx_byte;
    t_out_word  result;

    assign accept      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // receiver shift including this tick's bit
    assign rx_assembled = {r_rx_shift[6:0], i_in_word.rx_bit};

    // current message byte; past the end reads as a terminator
    always_comb begin
        tx_byte = FILL_LOW;
        if ((r_read_index < r_msg_length) && (r_read_index < MSG_DEPTH_CNT)) begin
            tx_byte = r_msg_store[r_read_index[MSG_IDX_W-1:0]];
        end
    end

    // ---------------- next state for one accepted word ----------------
    always_comb begin
        n_rx_shift     = r_rx_shift;
        n_rx_bit_count = r_rx_bit_count;
        n_calibrated   = r_calibrated;
        n_msg_length   = r_msg_length;
        n_msg_ready    = r_msg_ready;
        n_write_index  = r_write_index;
        n_read_index   = r_read_index;
        n_tx_bit_index = r_tx_bit_index;
        n_tx_phase     = r_tx_phase;
        n_line_level   = r_line_level;
        store_we       = 1'b0;
        result         = '0;

        case (i_in_word.req_type)
            REQ_CHAR: begin
                if (!r_msg_ready) begin
                    if (i_in_word.char_in == NEWLINE_CHAR) begin
                        // empty line is ignored
                        if (r_write_index != '0) begin
                            n_msg_length   = r_write_index;
                            n_msg_ready    = 1'b1;
                            n_write_index  = '0;
                            n_read_index   = '0;
                            n_tx_bit_index = BIT_TOP;
                        end
                    end else if (r_write_index < MSG_DEPTH_CNT) begin
                        // full buffer drops characters until newline
                        store_we      = 1'b1;
                        n_write_index = r_write_index + 1'b1;
                    end
                end
            end
            REQ_TICK: begin
                result.rx_byte = rx_assembled;
                // receiver
                if (!r_calibrated) begin
                    if (rx_assembled == r_sync_word) begin
                        n_calibrated       = 1'b1;
                        result.calib_event = 1'b1;
                    end
                    n_rx_shift = rx_assembled;
                end else if (r_rx_bit_count == '0) begin
                    result.rx_valid = (rx_assembled != r_sync_word) &&
                                      (rx_assembled != FILL_LOW) &&
                                      (rx_assembled != FILL_HIGH);
                    n_rx_bit_count  = BIT_TOP;
                    n_rx_shift      = '0;
                end else begin
                    n_rx_bit_count = r_rx_bit_count - 1'b1;
                    n_rx_shift     = rx_assembled;
                end

                // transmitter: message bits while phase sits at its top
                if (r_msg_ready && (r_tx_phase == BIT_TOP)) begin
                    if (tx_byte != FILL_LOW) begin
                        n_line_level = tx_byte[r_tx_bit_index];
                        if (r_tx_bit_index == '0) begin
                            n_read_index   = r_read_index + 1'b1;
                            n_tx_bit_index = BIT_TOP;
                        end else begin
                            n_tx_bit_index = r_tx_bit_index - 1'b1;
                        end
                    end else begin
                        n_msg_ready  = 1'b0;
                        n_read_index = '0;
                    end
                end
                // otherwise the phase runs; sync pattern until calibrated
                if (!n_msg_ready || (r_tx_phase != BIT_TOP)) begin
                    if (!n_calibrated) begin
                        n_line_level = r_sync_word[r_tx_phase];
                    end
                    n_tx_phase = r_tx_phase - 1'b1;
                end
            end
            default: begin
            end
        endcase

        result.tx_level    = n_line_level;
        result.msg_pending = n_msg_ready;
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_word    <= SYNC_RESET;
            r_rx_shift     <= '0;
            r_rx_bit_count <= BIT_TOP;
            r_calibrated   <= 1'b0;
            r_msg_length   <= '0;
            r_msg_ready    <= 1'b0;
            r_write_index  <= '0;
            r_read_index   <= '0;
            r_tx_bit_index <= BIT_TOP;
            r_tx_phase     <= BIT_TOP;
            r_line_level   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_sync_word <= i_cfg_data;
            end
            if (accept) begin
                r_rx_shift     <= n_rx_shift;
                r_rx_bit_count <= n_rx_bit_count;
                r_calibrated   <= n_calibrated;
                r_msg_length   <= n_msg_length;
                r_msg_ready    <= n_msg_ready;
                r_write_index  <= n_write_index;
                r_read_index   <= n_read_index;
                r_tx_bit_index <= n_tx_bit_index;
                r_tx_phase     <= n_tx_phase;
                r_line_level   <= n_line_level;
            end
        end
    end

    // message store, no reset: only written entries are ever read
    always_ff @(posedge i_clk) begin
        if (accept && store_we) begin
            r_msg_store[r_write_index[MSG_IDX_W-1:0]] <= i_in_word.char_in;
        end
    end

    // ---------------- output buffer ----------------
    swsl_out_skid u_out_skid (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (accept),
        .i_word     (result),
        .o_can_push (o_in_ready),
        .o_valid    (o_out_valid),
        .o_word     (o_out_word),
        .i_ready    (i_out_ready)
    );

endmodule

[rtl/core/swsl_out_skid.sv]
// -----------------------------------------------------------------------------
// swsl_out_skid
// Two-entry output buffer: result register plus skid register.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swsl_out_skid
    import swsl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_out_word i_word,
    output logic      o_can_push,
    output logic      o_valid,
    output t_out_word o_word,
    input  logic      i_ready
);

    logic      r_main_valid, n_main_valid;
    logic      r_skid_valid, n_skid_valid;
    t_out_word r_main, n_main;
    t_out_word r_skid, n_skid;

    assign o_can_push = !r_skid_valid;
    assign o_valid    = r_main_valid;
    assign o_word     = r_main;

    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        if (r_main_valid && i_ready) begin
            if (r_skid_valid) begin
                n_main       = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_main_valid = i_push;
                n_main       = i_word;
            end
        end else if (i_push) begin
            if (!r_main_valid) begin
                n_main_valid = 1'b1;
                n_main       = i_word;
            end else begin
                n_skid_valid = 1'b1;
                n_skid       = i_word;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_main <= n_main;
        r_skid <= n_skid;
    end

endmodule

[rtl/core/swsl_checker.sv]
// -----------------------------------------------------------------------------
// swsl_checker
// Port-level checks for the sync-word serial link core.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "sync_word_serial_link_core_assert.svh"

module swsl_checker
    import swsl_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input t_out_word  o_out_word
);

    logic in_fire;
    logic rx_fill;

    assign in_fire = i_in_valid && o_in_ready;
    assign rx_fill = (o_out_word.rx_byte == FILL_LOW) || (o_out_word.rx_byte == FILL_HIGH);

    // stalled result stays
    `SWSL_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid)
    `SWSL_ASSERT_NEXT(a_out_stable, o_out_valid && !i_out_ready, $stable(o_out_word))
    // calibration tick never reports data
    `SWSL_ASSERT_NOW(a_cal_excl, o_out_valid, !(o_out_word.rx_valid && o_out_word.calib_event))
    // fill bytes are never reported
    `SWSL_ASSERT_NOW(a_no_fill, o_out_valid && o_out_word.rx_valid, !rx_fill)
    // a fresh result needs a word accepted in the cycle before
    `SWSL_ASSERT_NOW(a_out_src, o_out_valid && !$past(o_out_valid) && $past(i_rst_n), $past(in_fire))

endmodule

bind sync_word_serial_link_core swsl_checker u_swsl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);
